// File: hdl/scl_pkg.sv
package scl_pkg;

    localparam int TAG_WIDTH_DEF = 32;
    localparam int GEN_WIDTH     = 32;

    typedef enum logic [2:0] {
        ST_OFFLINE = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_OPENING = 3'd2,
        ST_OPEN    = 3'd3,
        ST_CLOSING = 3'd4,
        ST_FAULTED = 3'd5
    } state_t;

    typedef enum logic [2:0] {
        OP_START      = 3'd0,
        OP_OPEN_REQ   = 3'd1,
        OP_CLOSE_REQ  = 3'd2,
        OP_DISCONNECT = 3'd3,
        OP_OPEN_DONE  = 3'd4,
        OP_CLOSE_DONE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_OPEN   = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_CLOSE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [2:0]           op;
        logic                 take_offline;
        logic [GEN_WIDTH-1:0] event_generation;
        logic                 succeeded;
        logic                 chan_delivered;
    } event_t;

    typedef struct packed {
        logic [1:0]           action;
        logic                 disconnect_taken;
        logic [2:0]           current_state;
        logic [GEN_WIDTH-1:0] current_generation;
        logic                 consistent;
    } result_t;

    // handshake between pipeline stages
    typedef struct packed {
        logic step;
        logic ready;
    } stage_ctrl_t;

endpackage

// File: hdl/scl_in_stage.sv
module scl_in_stage
    import scl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        event_valid,
    output logic        event_stall,
    input  event_t      event_item,
    input  logic        res_ready,
    output stage_ctrl_t ctrl,
    output event_t      item
);

    logic   valid_reg;
    logic   valid_next;
    event_t item_reg;
    logic   accept;
    logic   step;

    assign step        = valid_reg && res_ready;
    assign event_stall = valid_reg && !res_ready;
    assign accept      = event_valid && !event_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (step)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= event_item;
    end

    assign ctrl.step  = step;
    assign ctrl.ready = res_ready;
    assign item       = item_reg;

endmodule

// File: hdl/scl_core.sv
module scl_core
    import scl_pkg::*;
#(
    parameter int TAG_WIDTH = TAG_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_ctrl_t ctrl,
    input  event_t      item,
    output result_t     result
);

    localparam int CMP_W = (TAG_WIDTH > GEN_WIDTH) ? TAG_WIDTH : GEN_WIDTH;

    state_t               state_reg, state_next;
    logic                 pend_reg, pend_next;
    logic                 held_reg, held_next;
    logic                 creq_reg, creq_next;
    logic                 goff_reg, goff_next;
    logic                 started_reg, started_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;

    logic [TAG_WIDTH-1:0] tag_inc;
    logic                 gen_match;
    logic                 start_ok;
    logic                 open_ok;
    logic                 disc_ok;
    logic                 done_live;
    logic                 off_now;
    logic                 goff_req;
    logic [1:0]           action;

    assign tag_inc   = tag_reg + TAG_WIDTH'(1);
    assign gen_match = (CMP_W'(item.event_generation) == CMP_W'(tag_reg));
    assign start_ok  = !started_reg && (state_reg == ST_OFFLINE);
    assign open_ok   = started_reg && (state_reg == ST_CLOSED) && !pend_reg && !held_reg;
    assign disc_ok   = gen_match && started_reg && (state_reg == ST_OPEN) && held_reg;
    assign done_live = gen_match && pend_reg && (state_reg == ST_OPENING);
    assign off_now   = goff_reg || !started_reg;
    assign goff_req  = goff_reg || item.take_offline;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        held_next    = held_reg;
        creq_next    = creq_reg;
        goff_next    = goff_reg;
        started_next = started_reg;
        tag_next     = tag_reg;
        unique case (item.op)
            OP_START:
            begin
                if (start_ok)
                begin
                    started_next = 1'b1;
                    state_next   = ST_CLOSED;
                    pend_next    = 1'b0;
                    held_next    = 1'b0;
                    creq_next    = 1'b0;
                    goff_next    = 1'b0;
                    tag_next     = tag_inc;
                end
            end
            OP_OPEN_REQ:
            begin
                if (open_ok)
                begin
                    state_next = ST_OPENING;
                    pend_next  = 1'b1;
                    creq_next  = 1'b0;
                    goff_next  = 1'b0;
                end
            end
            OP_CLOSE_REQ:
            begin
                creq_next = 1'b1;
                goff_next = goff_req;
                if (item.take_offline)
                    started_next = 1'b0;
                priority if (state_reg == ST_OPENING && pend_reg)
                begin
                    state_next = state_reg;
                end
                else if (state_reg == ST_OPEN && held_reg)
                begin
                    state_next = ST_CLOSING;
                end
                else if (state_reg == ST_CLOSED || state_reg == ST_FAULTED ||
                         state_reg == ST_OFFLINE)
                begin
                    state_next = goff_req ? ST_OFFLINE : ST_CLOSED;
                    pend_next  = 1'b0;
                    held_next  = 1'b0;
                    creq_next  = 1'b0;
                    goff_next  = 1'b0;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            OP_DISCONNECT:
            begin
                if (disc_ok)
                begin
                    state_next = ST_FAULTED;
                    pend_next  = 1'b0;
                    held_next  = 1'b0;
                    creq_next  = 1'b0;
                    goff_next  = 1'b0;
                    tag_next   = (tag_inc == '0) ? TAG_WIDTH'(1) : tag_inc;
                end
            end
            OP_OPEN_DONE:
            begin
                if (done_live)
                begin
                    pend_next = 1'b0;
                    if (item.succeeded && item.chan_delivered)
                    begin
                        held_next  = 1'b1;
                        state_next = (creq_reg || off_now) ? ST_CLOSING : ST_OPEN;
                    end
                    else
                    begin
                        held_next = 1'b0;
                        creq_next = 1'b0;
                        goff_next = 1'b0;
                        priority if (off_now)
                            state_next = ST_OFFLINE;
                        else if (creq_reg)
                            state_next = ST_CLOSED;
                        else
                            state_next = ST_FAULTED;
                    end
                end
            end
            OP_CLOSE_DONE:
            begin
                if (state_reg == ST_CLOSING)
                begin
                    pend_next = 1'b0;
                    held_next = 1'b0;
                    creq_next = 1'b0;
                    goff_next = 1'b0;
                    priority if (off_now)
                        state_next = ST_OFFLINE;
                    else if (item.succeeded)
                        state_next = ST_CLOSED;
                    else
                        state_next = ST_FAULTED;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        action = ACT_NONE;
        unique case (item.op)
            OP_OPEN_REQ:
            begin
                if (open_ok)
                    action = ACT_OPEN;
            end
            OP_CLOSE_REQ:
            begin
                priority if (state_reg == ST_OPENING && pend_reg)
                    action = ACT_CANCEL;
                else if (state_reg == ST_OPEN && held_reg)
                    action = ACT_CLOSE;
                else
                    action = ACT_NONE;
            end
            OP_OPEN_DONE:
            begin
                priority if (!done_live)
                    action = item.chan_delivered ? ACT_CLOSE : ACT_NONE;
                else if (item.succeeded && item.chan_delivered && (creq_reg || off_now))
                    action = ACT_CLOSE;
                else
                    action = ACT_NONE;
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase

        result.action             = action;
        result.disconnect_taken   = (item.op == OP_DISCONNECT) && disc_ok;
        result.current_state      = state_next;
        result.current_generation = GEN_WIDTH'(tag_next);
        result.consistent         = (pend_next == (state_next == ST_OPENING)) &&
                                    (held_next == (state_next == ST_OPEN ||
                                                   state_next == ST_CLOSING)) &&
                                    !(!started_next && state_next != ST_OFFLINE &&
                                      !goff_next) &&
                                    !(state_next == ST_OFFLINE && started_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_OFFLINE;
            pend_reg    <= 1'b0;
            held_reg    <= 1'b0;
            creq_reg    <= 1'b0;
            goff_reg    <= 1'b0;
            started_reg <= 1'b0;
            tag_reg     <= '0;
        end
        else if (ctrl.step)
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            held_reg    <= held_next;
            creq_reg    <= creq_next;
            goff_reg    <= goff_next;
            started_reg <= started_next;
            tag_reg     <= tag_next;
        end
    end

endmodule

// File: hdl/scl_out_stage.sv
module scl_out_stage
    import scl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_ctrl_t ctrl,
    input  result_t     result,
    output logic        res_ready,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result_item
);

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;

    assign res_ready = !valid_reg || !result_stall;

    always_comb
    begin
        if (ctrl.step)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.ready)
            item_reg <= result;
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

// File: hdl/signaling_channel_lifecycle_fsm.sv
// Channel  | Direction | Payload  | Transfer
// event    | in        | event_t  | event_valid  && !event_stall
// result   | out       | result_t | result_valid && !result_stall
//
// One result per event; the event passes through the input register, then the result
// register, where result_valid rises; a stalled result holds the event in the input
// register. One event per cycle sustained while the result is not stalled.
// The lifecycle state and tag update as the event moves to the result register.
// rst_n clears state to offline, tag to zero and both stages to empty.
// event_stall rises only while the input register holds an event and the
// result register is full and stalled.
module signaling_channel_lifecycle_fsm
    import scl_pkg::*;
#(
    parameter int TAG_WIDTH = TAG_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    event_valid,
    output logic    event_stall,
    input  event_t  event_item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_item
);

    stage_ctrl_t ctrl;
    event_t      item;
    result_t     result;
    logic        res_ready;

    scl_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_item  (event_item),
        .res_ready   (res_ready),
        .ctrl        (ctrl),
        .item        (item)
    );

    scl_core #(
        .TAG_WIDTH (TAG_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .result (result)
    );

    scl_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .result       (result),
        .res_ready    (res_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// File: hdl/scl_checker.sv
module scl_checker
    import scl_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    event_valid,
    input logic    event_stall,
    input event_t  event_item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_item
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result changed");

    // stalled event transfer holds
    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=> event_valid && $stable(event_item))
        else $error("stalled event changed");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        event_stall |-> result_valid && result_stall)
        else $error("event stalled without output back-pressure");

    a_disconnect: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.disconnect_taken |->
            result_item.current_state == ST_FAULTED &&
            result_item.action == ACT_NONE &&
            result_item.current_generation != '0)
        else $error("disconnect result malformed");

    a_open_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_item.action == ACT_OPEN ||
                         result_item.action == ACT_CANCEL) |->
            result_item.current_state == ST_OPENING)
        else $error("open or cancel issued outside opening");

endmodule

bind signaling_channel_lifecycle_fsm scl_checker u_scl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_item   (event_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

// File: sim/scl_lifecycle_checker.sv
module scl_lifecycle_checker
    import scl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    event_valid,
    input  logic    event_stall,
    input  event_t  event_item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result_item,
    output int      fail_count,
    output int      outstanding
);

    state_t               lc_state;
    logic                 open_pend;
    logic                 chan_held;
    logic                 close_req;
    logic                 go_offline;
    logic                 is_started;
    logic [GEN_WIDTH-1:0] gen_tag;

    result_t expected_results[$];

    function automatic void drop_requests();
        open_pend  = 1'b0;
        chan_held  = 1'b0;
        close_req  = 1'b0;
        go_offline = 1'b0;
    endfunction

    function automatic logic flags_agree();
        if (open_pend != (lc_state == ST_OPENING))
            return 1'b0;
        if (chan_held != (lc_state == ST_OPEN || lc_state == ST_CLOSING))
            return 1'b0;
        if (!is_started && lc_state != ST_OFFLINE && !go_offline)
            return 1'b0;
        if (lc_state == ST_OFFLINE && is_started)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic result_t next_lifecycle_result(input event_t ev);
        action_t act;
        logic    taken;
        logic    to_off;
        result_t r;
        act   = ACT_NONE;
        taken = 1'b0;
        case (ev.op)
            OP_START:
            begin
                if (!is_started && lc_state == ST_OFFLINE)
                begin
                    is_started = 1'b1;
                    lc_state   = ST_CLOSED;
                    drop_requests();
                    gen_tag    = gen_tag + 1'b1;
                end
            end
            OP_OPEN_REQ:
            begin
                if (is_started && lc_state == ST_CLOSED && !open_pend && !chan_held)
                begin
                    lc_state   = ST_OPENING;
                    open_pend  = 1'b1;
                    close_req  = 1'b0;
                    go_offline = 1'b0;
                    act        = ACT_OPEN;
                end
            end
            OP_CLOSE_REQ:
            begin
                close_req = 1'b1;
                if (ev.take_offline)
                begin
                    go_offline = 1'b1;
                    is_started = 1'b0;
                end
                if (lc_state == ST_OPENING && open_pend)
                    act = ACT_CANCEL;
                else if (lc_state == ST_OPEN && chan_held)
                begin
                    lc_state = ST_CLOSING;
                    act      = ACT_CLOSE;
                end
                else if (lc_state == ST_CLOSED || lc_state == ST_FAULTED ||
                         lc_state == ST_OFFLINE)
                begin
                    lc_state = go_offline ? ST_OFFLINE : ST_CLOSED;
                    drop_requests();
                end
            end
            OP_DISCONNECT:
            begin
                if (ev.event_generation == gen_tag && is_started &&
                    lc_state == ST_OPEN && chan_held)
                begin
                    lc_state = ST_FAULTED;
                    drop_requests();
                    gen_tag = gen_tag + 1'b1;
                    if (gen_tag == '0)
                        gen_tag = GEN_WIDTH'(1);
                    taken = 1'b1;
                end
            end
            OP_OPEN_DONE:
            begin
                if (ev.event_generation != gen_tag || !open_pend || lc_state != ST_OPENING)
                    act = ev.chan_delivered ? ACT_CLOSE : ACT_NONE;
                else
                begin
                    open_pend = 1'b0;
                    if (ev.succeeded && ev.chan_delivered)
                    begin
                        chan_held = 1'b1;
                        if (close_req || go_offline || !is_started)
                        begin
                            lc_state = ST_CLOSING;
                            act      = ACT_CLOSE;
                        end
                        else
                            lc_state = ST_OPEN;
                    end
                    else
                    begin
                        chan_held = 1'b0;
                        if (go_offline || !is_started)
                            lc_state = ST_OFFLINE;
                        else if (close_req)
                            lc_state = ST_CLOSED;
                        else
                            lc_state = ST_FAULTED;
                        close_req  = 1'b0;
                        go_offline = 1'b0;
                    end
                end
            end
            OP_CLOSE_DONE:
            begin
                if (lc_state == ST_CLOSING)
                begin
                    to_off = go_offline || !is_started;
                    drop_requests();
                    if (to_off)
                        lc_state = ST_OFFLINE;
                    else
                        lc_state = ev.succeeded ? ST_CLOSED : ST_FAULTED;
                end
            end
            default:
            begin
            end
        endcase
        r.action             = act;
        r.disconnect_taken   = taken;
        r.current_state      = lc_state;
        r.current_generation = gen_tag;
        r.consistent         = flags_agree();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout int errs);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int      errs;
        result_t want;
        if (!rst_n)
        begin
            lc_state   = ST_OFFLINE;
            is_started = 1'b0;
            gen_tag    = '0;
            drop_requests();
            expected_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, result_item);
                    errs++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("action", want.action, result_item.action, errs);
                    check_field("disconnect_taken", want.disconnect_taken,
                                result_item.disconnect_taken, errs);
                    check_field("current_state", want.current_state,
                                result_item.current_state, errs);
                    check_field("current_generation", want.current_generation,
                                result_item.current_generation, errs);
                    check_field("consistent", want.consistent, result_item.consistent, errs);
                end
            end
            if (event_valid && !event_stall)
                expected_results.push_back(next_lifecycle_result(event_item));
            fail_count  <= fail_count + errs;
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: sim/tb_signaling_channel_lifecycle_fsm.sv
module tb_signaling_channel_lifecycle_fsm;
    import scl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 362;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    event_valid  = 1'b0;
    logic    event_stall;
    event_t  event_item   = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_item;

    int fail_count;
    int outstanding;
    int events_sent = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;

    logic [GEN_WIDTH-1:0] tag_seen = '0;

    signaling_channel_lifecycle_fsm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_item   (event_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    scl_lifecycle_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_item   (event_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // recent tag, used to aim completions and disconnects at the live generation
    always @(negedge clk)
        if (rst_n && result_valid)
            tag_seen <= result_item.current_generation;

    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && events_sent >= 120)
            begin
                result_stall <= 1'b1;
                hold_left = 250;
                hold_done = 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic event_t mk_event(input logic [2:0] op, input logic tgt,
                                        input logic [GEN_WIDTH-1:0] g,
                                        input logic ok, input logic acq);
        event_t ev;
        ev.op               = op;
        ev.take_offline     = tgt;
        ev.event_generation = g;
        ev.succeeded        = ok;
        ev.chan_delivered   = acq;
        return ev;
    endfunction

    function automatic logic [GEN_WIDTH-1:0] pick_gen();
        case ($urandom_range(9))
            5, 6:    return tag_seen + 1'b1;
            7:       return tag_seen + 2'd2;
            8:       return $urandom;
            9:       return $urandom_range(1) ? '1 : '0;
            default: return tag_seen;
        endcase
    endfunction

    task automatic send_event(input event_t ev);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            event_valid <= 1'b0;
            @(negedge clk);
        end
        event_valid <= 1'b1;
        event_item  <= ev;
        do
            @(posedge clk);
        while (!(event_valid && !event_stall));
        events_sent++;
    endtask

    task automatic run_lifecycle();
        if ($urandom_range(1))
            send_event(mk_event(OP_START, 1'b0, pick_gen(), 1'($urandom), 1'($urandom)));
        send_event(mk_event(OP_OPEN_REQ, 1'b0, $urandom, 1'($urandom), 1'($urandom)));
        if ($urandom_range(4) == 0)
            send_event(mk_event(OP_CLOSE_REQ, $urandom_range(3) == 0, $urandom,
                                1'($urandom), 1'($urandom)));
        send_event(mk_event(OP_OPEN_DONE, 1'($urandom), pick_gen(),
                            $urandom_range(9) != 0, $urandom_range(9) != 0));
        case ($urandom_range(3))
            0:
            begin
                send_event(mk_event(OP_DISCONNECT, 1'($urandom), pick_gen(),
                                    1'($urandom), 1'($urandom)));
                send_event(mk_event(OP_CLOSE_REQ, $urandom_range(3) == 0, $urandom,
                                    1'($urandom), 1'($urandom)));
            end
            1, 2:
            begin
                send_event(mk_event(OP_CLOSE_REQ, $urandom_range(3) == 0, $urandom,
                                    1'($urandom), 1'($urandom)));
                send_event(mk_event(OP_CLOSE_DONE, 1'($urandom), $urandom,
                                    $urandom_range(3) != 0, 1'($urandom)));
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin : stimulus
        int goal;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_event(mk_event(3'd6, 1'b1, '1, 1'b1, 1'b1));
        send_event(mk_event(3'd7, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_REQ, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_REQ, 1'b1, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_DONE, 1'b0, '0, 1'b1, 1'b0));
        send_event(mk_event(OP_START, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_START, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_OPEN_REQ, 1'b0, '0, 1'b0, 1'b0));
        // stale completions, with and without a channel to hand back
        send_event(mk_event(OP_OPEN_DONE, 1'b0, 32'd0, 1'b1, 1'b1));
        send_event(mk_event(OP_OPEN_DONE, 1'b0, '1, 1'b1, 1'b0));
        // failed open that still delivered a channel
        send_event(mk_event(OP_OPEN_DONE, 1'b0, 32'd1, 1'b0, 1'b1));
        send_event(mk_event(OP_DISCONNECT, 1'b0, 32'd1, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_REQ, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_OPEN_REQ, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_OPEN_DONE, 1'b0, 32'd1, 1'b1, 1'b1));
        send_event(mk_event(OP_DISCONNECT, 1'b0, 32'd0, 1'b0, 1'b0));
        send_event(mk_event(OP_DISCONNECT, 1'b0, 32'd1, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_REQ, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_OPEN_REQ, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_REQ, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_OPEN_DONE, 1'b0, 32'd2, 1'b1, 1'b1));
        send_event(mk_event(OP_CLOSE_DONE, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_CLOSE_REQ, 1'b1, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_START, 1'b0, '0, 1'b0, 1'b0));
        send_event(mk_event(OP_OPEN_REQ, 1'b0, '0, 1'b0, 1'b0));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 66; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            goal = events_sent + PHASE_ITEMS;
            while (events_sent < goal)
            begin
                if ($urandom_range(99) < 65)
                    run_lifecycle();
                else
                    send_event(mk_event(3'($urandom_range(7)), 1'($urandom), pick_gen(),
                                        1'($urandom), 1'($urandom)));
            end
        end

        @(negedge clk);
        event_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
